// ===== hdl/cursor_sequence_store_assert.svh =====
// Assertion macros for the cursor sequence store.
// Implication check in the same cycle and check in the following cycle.
`ifndef CURSOR_SEQUENCE_STORE_ASSERT_SVH
`define CURSOR_SEQUENCE_STORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cursor_sequence_store: same-cycle check failed");
`define CSS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cursor_sequence_store: next-cycle check failed");
`else
`define CSS_ASSERT_IMP(label, clk, rst, ante, cons)
`define CSS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/css_pkg.sv =====
package css_pkg;

   // default sizing
   localparam int DEF_STORE_DEPTH = 32;
   localparam int DEF_WORD_BITS   = 32;

   // fixed beat field widths
   localparam int REQ_TYPE_BITS = 3;
   localparam int ENTRY_BITS    = 32;
   localparam int STATUS_BITS   = 2;
   localparam int COUNT_BITS    = 6;

   // request kinds
   localparam logic [REQ_TYPE_BITS-1:0] REQ_START   = 3'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_ADVANCE = 3'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_INSERT  = 3'd2;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_ATTACH  = 3'd3;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_REMOVE  = 3'd4;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STAT_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_NOCUR = 2'd2;

endpackage

// ===== hdl/css_if.sv =====
// Request channel: one command beat per request.
interface css_req_if;
   import css_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [REQ_TYPE_BITS-1:0] req_type;
   logic [ENTRY_BITS-1:0]    entry_value;

   modport source (output valid, output req_type, output entry_value, input ready);
   modport sink   (input valid, input req_type, input entry_value, output ready);
endinterface

// Response channel: one status beat per request.
interface css_rsp_if;
   import css_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [COUNT_BITS-1:0]  item_count;
   logic                   has_current;
   logic [ENTRY_BITS-1:0]  current_value;

   modport source (output valid, output status, output item_count, output has_current,
                   output current_value, input ready);
   modport sink   (input valid, input status, input item_count, input has_current,
                   input current_value, output ready);
endinterface

// ===== hdl/cursor_sequence_store.sv =====
// Sequence: start, advance, refused and unknown requests pass from the request beat
// through FETCH and RESULT; insert/attach/remove first move one word per cycle in SHIFT,
// then drain in FLUSH when any word moves, and insert/attach store the word in PUT.
// The longest run is an insert at the front of a store of STORE_DEPTH-1 words.
// One request at a time; the next request beat is taken the cycle after the response loads.
// Synchronous active-high reset empties the store and zeroes the cursor; no clearing pass.
module cursor_sequence_store #(
   parameter int STORE_DEPTH = css_pkg::DEF_STORE_DEPTH,
   parameter int WORD_BITS   = css_pkg::DEF_WORD_BITS
) (
   input  logic          clock,
   input  logic          reset,
   css_req_if.sink       req_bus,
   css_rsp_if.source     rsp_bus
);
   import css_pkg::*;

`include "cursor_sequence_store_assert.svh"

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = $clog2(STORE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_FLUSH,
      S_PUT,
      S_FETCH,
      S_RESULT
   } state_type;

   state_type                state_ff;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            cursor_ff;
   logic [WORD_BITS-1:0]     word_ff;
   logic [STATUS_BITS-1:0]   status_ff;
   logic [CW-1:0]            src_ff;
   logic [CW-1:0]            dst_ff;
   logic [CW-1:0]            left_ff;
   logic                     up_ff;
   logic                     wr_pend_ff;
   logic [AW-1:0]            wr_addr_ff;

   logic                     rsp_valid_ff;
   logic [STATUS_BITS-1:0]   rsp_status_ff;
   logic [COUNT_BITS-1:0]    rsp_count_ff;
   logic                     rsp_has_ff;
   logic [ENTRY_BITS-1:0]    rsp_value_ff;

   // word memory, one write and one registered read per cycle
   logic [WORD_BITS-1:0]     store_ff [STORE_DEPTH];
   logic [WORD_BITS-1:0]     rd_ff;

   logic                     fire;
   logic                     on_item;
   logic                     full;
   logic [CW-1:0]            ins_pos;
   logic                     mem_we;
   logic [AW-1:0]            mem_wa;
   logic [WORD_BITS-1:0]     mem_wd;
   logic                     mem_re;
   logic [AW-1:0]            mem_ra;
   logic                     remove_hit;
   logic                     rsp_full;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign fire          = req_bus.valid && req_bus.ready;
   assign on_item       = (cursor_ff < count_ff);
   assign full          = (count_ff >= CW'(STORE_DEPTH));

   // landing slot for a new word
   always_comb begin
      if (req_bus.req_type == REQ_INSERT) begin
         ins_pos = on_item ? cursor_ff : '0;
      end else begin
         ins_pos = on_item ? (cursor_ff + CW'(1)) : count_ff;
      end
   end

   // memory port selection; PUT never overlaps a pending shift write
   always_comb begin
      mem_we = wr_pend_ff || (state_ff == S_PUT);
      mem_wa = (state_ff == S_PUT) ? cursor_ff[AW-1:0] : wr_addr_ff;
      mem_wd = (state_ff == S_PUT) ? word_ff : rd_ff;
      mem_re = (state_ff == S_SHIFT) || ((state_ff == S_FETCH) && on_item);
      mem_ra = (state_ff == S_SHIFT) ? src_ff[AW-1:0] : cursor_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= store_ff[mem_ra];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pend_ff <= 1'b0;
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (fire) begin
                  word_ff   <= WORD_BITS'(req_bus.entry_value);
                  status_ff <= STAT_DONE;
                  state_ff  <= S_FETCH;
                  case (req_bus.req_type)
                     REQ_START: begin
                        cursor_ff <= '0;
                     end
                     REQ_ADVANCE: begin
                        if (on_item) begin
                           cursor_ff <= cursor_ff + CW'(1);
                        end else begin
                           status_ff <= STAT_NOCUR;
                        end
                     end
                     REQ_INSERT, REQ_ATTACH: begin
                        if (full) begin
                           status_ff <= STAT_FULL;
                        end else begin
                           cursor_ff <= ins_pos;
                           count_ff  <= count_ff + CW'(1);
                           src_ff    <= count_ff - CW'(1);
                           dst_ff    <= count_ff;
                           left_ff   <= count_ff - ins_pos;
                           up_ff     <= 1'b0;
                           state_ff  <= (count_ff == ins_pos) ? S_PUT : S_SHIFT;
                        end
                     end
                     REQ_REMOVE: begin
                        if (!on_item) begin
                           status_ff <= STAT_NOCUR;
                        end else begin
                           count_ff <= count_ff - CW'(1);
                           src_ff   <= cursor_ff + CW'(1);
                           dst_ff   <= cursor_ff;
                           left_ff  <= count_ff - CW'(1) - cursor_ff;
                           up_ff    <= 1'b1;
                           if (count_ff - CW'(1) != cursor_ff) begin
                              state_ff <= S_SHIFT;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            // move one word per cycle: read src now, write dst next cycle
            S_SHIFT: begin
               wr_pend_ff <= 1'b1;
               wr_addr_ff <= dst_ff[AW-1:0];
               src_ff     <= up_ff ? (src_ff + CW'(1)) : (src_ff - CW'(1));
               dst_ff     <= up_ff ? (dst_ff + CW'(1)) : (dst_ff - CW'(1));
               left_ff    <= left_ff - CW'(1);
               if (left_ff == CW'(1)) begin
                  state_ff <= S_FLUSH;
               end
            end
            S_FLUSH: begin
               state_ff <= up_ff ? S_FETCH : S_PUT;
            end
            S_PUT: begin
               state_ff <= S_FETCH;
            end
            S_FETCH: begin
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_count_ff  <= COUNT_BITS'(count_ff);
                  rsp_has_ff    <= on_item;
                  rsp_value_ff  <= on_item ? ENTRY_BITS'(rd_ff) : '0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.item_count    = rsp_count_ff;
   assign rsp_bus.has_current   = rsp_has_ff;
   assign rsp_bus.current_value = rsp_value_ff;

   // checks
   assign remove_hit = fire && (req_bus.req_type == REQ_REMOVE) && on_item;
   assign rsp_full   = rsp_valid_ff && (rsp_status_ff == STAT_FULL);

   `CSS_ASSERT_IMP(a_cursor_in_range, clock, reset, 1'b1, cursor_ff <= count_ff)
   `CSS_ASSERT_IMP(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(STORE_DEPTH))
   `CSS_ASSERT_IMP(a_no_port_clash, clock, reset, wr_pend_ff && mem_re, wr_addr_ff != mem_ra)
   `CSS_ASSERT_IMP(a_idle_no_write, clock, reset, state_ff == S_IDLE, !wr_pend_ff)
   `CSS_ASSERT_NXT(a_remove_shrinks, clock, reset, remove_hit, count_ff == $past(count_ff) - CW'(1))
   `CSS_ASSERT_IMP(a_full_count, clock, reset, rsp_full, rsp_count_ff == COUNT_BITS'(STORE_DEPTH))

endmodule
